FILE: sv/dfas_pkg.sv
// Shared types, constants and digit helpers for the decimal float add/subtract pipeline.
// No dependencies.
`default_nettype none
package dfas_pkg;

  localparam int DIGITS_DEF = 16;
  localparam int MANT_W     = 64;
  localparam int EXP_W      = 11;
  localparam int EXP_WIDE_W = 13;

  localparam logic signed [EXP_WIDE_W-1:0] EXP_MIN = -13'sd1024;
  localparam logic signed [EXP_WIDE_W-1:0] EXP_MAX = 13'sd1023;

  typedef struct packed {
    logic                         valid;
    logic                         sign;
    logic                         sub;
    logic signed [EXP_WIDE_W-1:0] exp;
  } dfas_ctl_t;

  function automatic logic [3:0] clamp_digit(input logic [3:0] d);
    return (d > 4'd9) ? 4'd9 : d;
  endfunction

  function automatic logic [4:0] digit_add(input logic [3:0] a, input logic [3:0] b,
                                           input logic cin);
    logic [4:0] s;
    s = 5'(a) + 5'(b) + 5'(cin);
    if (s > 5'd9) begin
      return {1'b1, 4'(s - 5'd10)};
    end
    return {1'b0, s[3:0]};
  endfunction

endpackage
`default_nettype wire

FILE: sv/dfas_if.sv
// Handshake channels for operand words and result words.
// Depends on nothing.
`default_nettype none
interface dfas_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic               a_sign;
  logic signed [10:0] a_exponent;
  logic [63:0]        a_digits;
  logic               b_sign;
  logic signed [10:0] b_exponent;
  logic [63:0]        b_digits;

  modport source (output valid, command, a_sign, a_exponent, a_digits,
                  b_sign, b_exponent, b_digits, input ready);
  modport sink (input valid, command, a_sign, a_exponent, a_digits,
                b_sign, b_exponent, b_digits, output ready);
endinterface

interface dfas_out_if;
  logic               valid;
  logic               ready;
  logic               result_sign;
  logic signed [10:0] result_exponent;
  logic [63:0]        result_digits;
  logic               exponent_out_of_range;

  modport source (output valid, result_sign, result_exponent, result_digits,
                  exponent_out_of_range, input ready);
  modport sink (input valid, result_sign, result_exponent, result_digits,
                exponent_out_of_range, output ready);
endinterface
`default_nettype wire

FILE: sv/dfas_align.sv
// Stages 1-2: digit clamp, effective sign, exponent compare and operand swap, then
// right alignment of the smaller-exponent mantissa. Depends on dfas_pkg, dfas_if.
`default_nettype none
module dfas_align #(
  parameter int DIGITS = dfas_pkg::DIGITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  dfas_in_if.sink                     operands,
  output dfas_pkg::dfas_ctl_t         ctl,
  output logic [4*DIGITS-1:0]         x,
  output logic [4*DIGITS-1:0]         y
);
  localparam int W  = 4 * DIGITS;
  localparam int SW = $clog2(DIGITS + 1);
  localparam int EW = dfas_pkg::EXP_WIDE_W;

  logic [W-1:0]          da, db;
  logic                  za, zb, sb, a_ge;
  logic signed [EW-1:0]  ea, eb, ea_use, eb_use;
  logic [EW-1:0]         diff;
  logic [SW-1:0]         shift;

  logic                  v1;
  logic [W-1:0]          x1, y1;
  logic [SW-1:0]         sh1;
  logic signed [EW-1:0]  e1;
  logic                  sx1, sy1;

  assign operands.ready = en;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      da[4*i +: 4] = dfas_pkg::clamp_digit(operands.a_digits[4*i +: 4]);
      db[4*i +: 4] = dfas_pkg::clamp_digit(operands.b_digits[4*i +: 4]);
    end
    za     = (da == '0);
    zb     = (db == '0);
    sb     = operands.b_sign ^ operands.command;
    ea     = EW'(operands.a_exponent);
    eb     = EW'(operands.b_exponent);
    ea_use = za ? eb : ea;
    eb_use = zb ? ea : eb;
    a_ge   = (ea_use >= eb_use);
    diff   = a_ge ? EW'(ea_use - eb_use) : EW'(eb_use - ea_use);
    shift  = (diff >= EW'(DIGITS)) ? SW'(DIGITS) : diff[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      v1        <= operands.valid;
      ctl.valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1       <= a_ge ? da : db;
      y1       <= a_ge ? db : da;
      sh1      <= shift;
      e1       <= a_ge ? ea_use : eb_use;
      sx1      <= a_ge ? operands.a_sign : sb;
      sy1      <= a_ge ? sb : operands.a_sign;
      x        <= x1;
      y        <= y1 >> {sh1, 2'b00};
      ctl.sign <= sx1;
      ctl.sub  <= sx1 ^ sy1;
      ctl.exp  <= e1;
    end
  end
endmodule
`default_nettype wire

FILE: sv/dfas_addsub.sv
// Stages 3-5: magnitude compare and swap, then BCD add or ten's-complement subtract
// split into a low-half and a high-half carry chain. Depends on dfas_pkg.
`default_nettype none
module dfas_addsub #(
  parameter int DIGITS = dfas_pkg::DIGITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire dfas_pkg::dfas_ctl_t    ctl_in,
  input  wire logic [4*DIGITS-1:0]    x,
  input  wire logic [4*DIGITS-1:0]    y,
  output dfas_pkg::dfas_ctl_t         ctl,
  output logic [4*DIGITS-1:0]         sum,
  output logic                        cout
);
  localparam int W  = 4 * DIGITS;
  localparam int LO = DIGITS / 2;
  localparam int HI = DIGITS - LO;

  logic                 swap;
  dfas_pkg::dfas_ctl_t  ctl3, ctl4;
  logic [W-1:0]         big3, small3, small_eff;
  logic [4*LO-1:0]      lo_sum, lo4;
  logic                 lo_c, c4;
  logic [4*HI-1:0]      big_hi4, small_hi4, hi_sum;
  logic                 hi_c;
  logic [4:0]           r_lo, r_hi;

  assign swap = ctl_in.sub && (y > x);

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      small_eff[4*i +: 4] = ctl3.sub ? 4'(4'd9 - small3[4*i +: 4]) : small3[4*i +: 4];
    end
    lo_c   = ctl3.sub;
    lo_sum = '0;
    r_lo   = '0;
    for (int i = 0; i < LO; i++) begin
      r_lo            = dfas_pkg::digit_add(big3[4*i +: 4], small_eff[4*i +: 4], lo_c);
      lo_sum[4*i +: 4] = r_lo[3:0];
      lo_c            = r_lo[4];
    end
    hi_c   = c4;
    hi_sum = '0;
    r_hi   = '0;
    for (int i = 0; i < HI; i++) begin
      r_hi             = dfas_pkg::digit_add(big_hi4[4*i +: 4], small_hi4[4*i +: 4], hi_c);
      hi_sum[4*i +: 4] = r_hi[3:0];
      hi_c             = r_hi[4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3.valid <= 1'b0;
      ctl4.valid <= 1'b0;
      ctl.valid  <= 1'b0;
    end else if (en) begin
      ctl3.valid <= ctl_in.valid;
      ctl4.valid <= ctl3.valid;
      ctl.valid  <= ctl4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big3      <= swap ? y : x;
      small3    <= swap ? x : y;
      ctl3.sign <= ctl_in.sign ^ swap;
      ctl3.sub  <= ctl_in.sub;
      ctl3.exp  <= ctl_in.exp;
      lo4       <= lo_sum;
      c4        <= lo_c;
      big_hi4   <= big3[W-1 -: 4*HI];
      small_hi4 <= small_eff[W-1 -: 4*HI];
      ctl4.sign <= ctl3.sign;
      ctl4.sub  <= ctl3.sub;
      ctl4.exp  <= ctl3.exp;
      sum       <= {hi_sum, lo4};
      cout      <= hi_c && !ctl4.sub;
      ctl.sign  <= ctl4.sign;
      ctl.sub   <= ctl4.sub;
      ctl.exp   <= ctl4.exp;
    end
  end
endmodule
`default_nettype wire

FILE: sv/dfas_norm.sv
// Stage 6: carry shift, leading-zero normalize, exponent range check and the
// output register. Depends on dfas_pkg, dfas_if.
`default_nettype none
module dfas_norm #(
  parameter int DIGITS = dfas_pkg::DIGITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire dfas_pkg::dfas_ctl_t    ctl_in,
  input  wire logic [4*DIGITS-1:0]    sum,
  input  wire logic                   cout,
  dfas_out_if.source                  result
);
  localparam int W  = 4 * DIGITS;
  localparam int SW = $clog2(DIGITS + 1);
  localparam int EW = dfas_pkg::EXP_WIDE_W;

  logic [W-1:0]         m, mn;
  logic signed [EW-1:0] e, en_exp;
  logic [SW-1:0]        lz;
  logic                 zero;

  always_comb begin
    m  = cout ? {4'd1, sum[W-1:4]} : sum;
    e  = ctl_in.exp + EW'(cout);
    lz = SW'(DIGITS);
    for (int i = 0; i < DIGITS; i++) begin
      if (m[4*i +: 4] != 4'd0) begin
        lz = SW'(DIGITS - 1 - i);
      end
    end
    zero   = (m == '0);
    mn     = m << {lz, 2'b00};
    en_exp = e - $signed(EW'(lz));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.result_sign           <= zero ? 1'b0 : ctl_in.sign;
      result.result_exponent       <= zero ? 11'sd0 : en_exp[10:0];
      result.result_digits         <= dfas_pkg::MANT_W'(mn);
      result.exponent_out_of_range <= !zero &&
        ((en_exp < dfas_pkg::EXP_MIN) || (en_exp > dfas_pkg::EXP_MAX));
    end
  end
endmodule
`default_nettype wire

FILE: sv/decimal_float_add_subtract.sv
// Decimal floating add/subtract: six-stage pipeline, one word per cycle while the output is not stalled.
// The BCD carry chain is split into a low and a high half.
// All stages advance together when the output register is empty or taken; a stall holds all.
// Reset clears the valid bits only. Depends on dfas_pkg, dfas_if, dfas_align,
// dfas_addsub, dfas_norm.
`default_nettype none
module decimal_float_add_subtract #(
  parameter int DIGITS = dfas_pkg::DIGITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  dfas_in_if.sink    operands,
  dfas_out_if.source result
);
  localparam int W = 4 * DIGITS;

  logic                en;
  dfas_pkg::dfas_ctl_t ctl_al, ctl_as;
  logic [W-1:0]        x, y, sum;
  logic                cout;

  assign en = !result.valid || result.ready;

  dfas_align #(.DIGITS(DIGITS)) u_align (
    .clk(clk), .rst(rst), .en(en), .operands(operands),
    .ctl(ctl_al), .x(x), .y(y)
  );

  dfas_addsub #(.DIGITS(DIGITS)) u_addsub (
    .clk(clk), .rst(rst), .en(en), .ctl_in(ctl_al), .x(x), .y(y),
    .ctl(ctl_as), .sum(sum), .cout(cout)
  );

  dfas_norm #(.DIGITS(DIGITS)) u_norm (
    .clk(clk), .rst(rst), .en(en), .ctl_in(ctl_as), .sum(sum), .cout(cout),
    .result(result)
  );
endmodule
`default_nettype wire

FILE: dv/tb_decimal_float_add_subtract.sv
// Testbench for decimal_float_add_subtract: random and directed operand words, with
// an in-bench decimal add/subtract predictor and an in-order result scoreboard.
// Depends on dfas_pkg, dfas_if and the decimal_float_add_subtract RTL.
`default_nettype none
module tb_decimal_float_add_subtract;

  localparam int NDIG = dfas_pkg::DIGITS_DEF;
  localparam int MANT_W = dfas_pkg::MANT_W;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    bit                 command;
    bit                 a_sign;
    bit signed [10:0]   a_exponent;
    bit [MANT_W-1:0]    a_digits;
    bit                 b_sign;
    bit signed [10:0]   b_exponent;
    bit [MANT_W-1:0]    b_digits;
    bit                 drain;
  } operand_word_t;

  typedef struct {
    bit                 sign;
    bit [10:0]          exponent;
    bit [MANT_W-1:0]    digits;
    bit                 out_of_range;
  } sum_word_t;

  logic clk;
  logic rst;
  dfas_in_if  op_if ();
  dfas_out_if res_if ();

  decimal_float_add_subtract dut (
    .clk      (clk),
    .rst      (rst),
    .operands (op_if),
    .result   (res_if)
  );

  operand_word_t pending_q[$];
  sum_word_t     expected_sums[$];
  int            cycle_count;
  int            idle_cycles;
  int            errors;

  function automatic bit [63:0] pow_ten(int n);
    bit [63:0] p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic bit [63:0] bcd_value(bit [63:0] bcd);
    bit [63:0] v;
    bit [3:0]  d;
    v = 0;
    for (int i = NDIG - 1; i >= 0; i--) begin
      d = bcd[4*i +: 4];
      if (d > 4'd9) d = 4'd9;
      v = v * 10 + d;
    end
    return v;
  endfunction

  function automatic bit [63:0] value_bcd(bit [63:0] v);
    bit [63:0] bcd;
    bcd = 0;
    for (int i = 0; i < NDIG; i++) begin
      bcd[4*i +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return bcd;
  endfunction

  function automatic sum_word_t predict_sum(operand_word_t w);
    sum_word_t r;
    bit [63:0] ma, mb, m;
    int        ea, eb, e, d;
    bit        sa, sb, s;
    sa = w.a_sign;
    sb = w.b_sign ^ w.command;
    ea = w.a_exponent;
    eb = w.b_exponent;
    ma = bcd_value(w.a_digits);
    mb = bcd_value(w.b_digits);
    m = 0; e = 0; s = 0;
    if (ma != 0 || mb != 0) begin
      if (ma == 0) ea = eb;
      if (mb == 0) eb = ea;
      if (ea >= eb) begin
        d = ea - eb;
        mb = (d >= NDIG) ? 64'd0 : mb / pow_ten(d);
        e = ea;
      end else begin
        d = eb - ea;
        ma = (d >= NDIG) ? 64'd0 : ma / pow_ten(d);
        e = eb;
      end
      if (sa == sb) begin
        m = ma + mb; s = sa;
      end else if (ma >= mb) begin
        m = ma - mb; s = sa;
      end else begin
        m = mb - ma; s = sb;
      end
    end
    if (m == 0) begin
      e = 0; s = 0;
    end else begin
      if (m >= pow_ten(NDIG)) begin
        m = m / 10; e = e + 1;
      end
      while (m < pow_ten(NDIG - 1)) begin
        m = m * 10; e = e - 1;
      end
    end
    r.sign = s;
    r.exponent = 11'(e);
    r.digits = value_bcd(m);
    r.out_of_range = (e < -1024 || e > 1023);
    return r;
  endfunction

  function automatic bit [63:0] rand_digits(int kind);
    bit [63:0] v;
    v = {$urandom, $urandom};
    case (kind)
      0: v = 0;
      1: begin
        for (int i = 0; i < NDIG; i++) v[4*i +: 4] = 4'($urandom_range(9));
        v[4*NDIG-4 +: 4] = 4'($urandom_range(9, 1));
      end
      2: begin
        for (int i = 0; i < NDIG; i++) v[4*i +: 4] = 4'($urandom_range(9));
        v = v >> (4 * $urandom_range(NDIG - 1, 1));
      end
      3: begin
        for (int i = 0; i < NDIG; i++) v[4*i +: 4] = $urandom_range(3) == 0 ? 4'(9) : 4'(0);
        v[4*NDIG-4 +: 4] = 4'($urandom_range(9, 1));
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic operand_word_t rand_word();
    operand_word_t w;
    int k;
    w.command = 1'($urandom_range(1));
    w.a_sign  = 1'($urandom_range(1));
    w.b_sign  = 1'($urandom_range(1));
    k = $urandom_range(99);
    w.a_digits = rand_digits(k < 70 ? 1 : k < 80 ? 2 : k < 88 ? 3 : k < 94 ? 4 : 0);
    k = $urandom_range(99);
    w.b_digits = rand_digits(k < 70 ? 1 : k < 80 ? 2 : k < 88 ? 3 : k < 94 ? 4 : 0);
    k = $urandom_range(99);
    if (k < 10) begin
      w.a_exponent = 11'($urandom);
      w.b_exponent = 11'($urandom);
    end else begin
      if (k < 20) w.a_exponent = $urandom_range(1) ? 11'h3FF - 11'($urandom_range(3))
                                                   : 11'h400 + 11'($urandom_range(3));
      else w.a_exponent = 11'($urandom);
      w.b_exponent = w.a_exponent + 11'($urandom_range(40)) - 11'd20;
    end
    if ($urandom_range(19) == 0) begin
      w.b_digits = w.a_digits;
      w.b_exponent = w.a_exponent;
    end
    w.drain = 0;
    return w;
  endfunction

  function automatic operand_word_t mk(bit c, bit as, int ae, bit [63:0] ad,
                                       bit bs, int be, bit [63:0] bd);
    operand_word_t w;
    w.command = c; w.a_sign = as; w.a_exponent = 11'(ae); w.a_digits = ad;
    w.b_sign = bs; w.b_exponent = 11'(be); w.b_digits = bd; w.drain = 0;
    return w;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    operand_word_t w;
    rst <= 1;
    pending_q.push_back(mk(0, 0, 0, 64'h0, 1, 5, 64'h0));
    pending_q.push_back(mk(1, 1, 7, 64'h0, 0, -3, 64'h1234567890123456));
    pending_q.push_back(mk(0, 0, 4, 64'h5000000000000000, 1, -900, 64'h0));
    pending_q.push_back(mk(1, 0, 3, 64'h1234567890123456, 0, 3, 64'h1234567890123456));
    pending_q.push_back(mk(0, 1, 9, 64'h9999999999999999, 0, 9, 64'h9999999999999999));
    pending_q.push_back(mk(0, 0, 1023, 64'h9999999999999999, 0, 1023, 64'h9999999999999999));
    pending_q.push_back(mk(1, 1, 1023, 64'h9999999999999999, 0, 1023, 64'h5000000000000000));
    pending_q.push_back(mk(0, 0, -1024, 64'h0000000100000000, 0, -1024, 64'h0));
    pending_q.push_back(mk(1, 0, -1024, 64'h1000000000000001, 0, -1024, 64'h1000000000000000));
    pending_q.push_back(mk(0, 0, 0, 64'hFFFFFFFFFFFFFFFF, 0, 0, 64'hABCDEF0123456789));
    pending_q.push_back(mk(0, 0, 100, 64'h1000000000000000, 0, 84, 64'h9999999999999999));
    pending_q.push_back(mk(0, 0, 100, 64'h1000000000000000, 0, 85, 64'h9999999999999999));
    pending_q.push_back(mk(1, 0, 0, 64'h0000000000012345, 0, 2, 64'h0000000000000012));
    pending_q.push_back(mk(0, 1, -5, 64'h0012000000000000, 0, -5, 64'h0000300000000000));
    pending_q.push_back(mk(1, 0, -1, 64'h1000000000000000, 0, -2, 64'h9999999999999999));
    pending_q.push_back(mk(1, 1, 1023, 64'h5000000000000000, 1, -1024, 64'h7000000000000000));
    pending_q.push_back(mk(0, 1, -1024, 64'h5000000000000000, 0, 1023, 64'h7000000000000000));
    pending_q.push_back(mk(0, 0, 2, 64'h5555555555555555, 0, 2, 64'h4444444444444445));
    for (int i = 0; i < 1900; i++) begin
      w = rand_word();
      if (i == 900) w.drain = 1;
      pending_q.push_back(w);
    end
    repeat (12) @(posedge clk);
    rst <= 0;
    forever begin
      @(posedge clk);
      if (pending_q.size() == 0 && !op_if.valid && expected_sums.size() == 0) break;
    end
    repeat (20) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      cycle_count <= 0;
      idle_cycles <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if ((op_if.valid && op_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, %0d words outstanding", $time, expected_sums.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic bit idle_now();
    if (cycle_count >= 600 && cycle_count < 1400) return 0;
    return $urandom_range(99) < 22;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      op_if.valid      <= 0;
      op_if.command    <= 0;
      op_if.a_sign     <= 0;
      op_if.a_exponent <= 0;
      op_if.a_digits   <= 0;
      op_if.b_sign     <= 0;
      op_if.b_exponent <= 0;
      op_if.b_digits   <= 0;
      res_if.ready     <= 0;
    end else begin
      res_if.ready <= !idle_now();
      if (!op_if.valid || op_if.ready) begin
        if (pending_q.size() != 0 && !idle_now() &&
            !(pending_q[0].drain && (op_if.valid || expected_sums.size() != 0))) begin
          op_if.valid      <= 1;
          op_if.command    <= pending_q[0].command;
          op_if.a_sign     <= pending_q[0].a_sign;
          op_if.a_exponent <= pending_q[0].a_exponent;
          op_if.a_digits   <= pending_q[0].a_digits;
          op_if.b_sign     <= pending_q[0].b_sign;
          op_if.b_exponent <= pending_q[0].b_exponent;
          op_if.b_digits   <= pending_q[0].b_digits;
          void'(pending_q.pop_front());
        end else begin
          op_if.valid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    operand_word_t w;
    sum_word_t     want;
    int            bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
    end else begin
      if (op_if.valid && op_if.ready) begin
        w.command    = op_if.command;
        w.a_sign     = op_if.a_sign;
        w.a_exponent = op_if.a_exponent;
        w.a_digits   = op_if.a_digits;
        w.b_sign     = op_if.b_sign;
        w.b_exponent = op_if.b_exponent;
        w.b_digits   = op_if.b_digits;
        w.drain      = 0;
        expected_sums.push_back(predict_sum(w));
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h %h %h %b", $time,
                   res_if.result_sign, res_if.result_exponent, res_if.result_digits,
                   res_if.exponent_out_of_range);
          bad = bad + 1;
        end else begin
          want = expected_sums.pop_front();
          if (res_if.result_sign !== want.sign) begin
            $display("%0t: result_sign expected %b actual %b", $time, want.sign,
                     res_if.result_sign);
            bad = bad + 1;
          end
          if (res_if.result_exponent !== want.exponent) begin
            $display("%0t: result_exponent expected %h actual %h", $time, want.exponent,
                     res_if.result_exponent);
            bad = bad + 1;
          end
          if (res_if.result_digits !== want.digits) begin
            $display("%0t: result_digits expected %h actual %h", $time, want.digits,
                     res_if.result_digits);
            bad = bad + 1;
          end
          if (res_if.exponent_out_of_range !== want.out_of_range) begin
            $display("%0t: exponent_out_of_range expected %b actual %b", $time,
                     want.out_of_range, res_if.exponent_out_of_range);
            bad = bad + 1;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
  end
endmodule
`default_nettype wire
